>>> sv/sspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int CAPACITY  = 16;
    localparam int PRIO_W    = 16;
    localparam int PRIO_IN_W = 16;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic execute;   // update the slots and load the result register
    } t_dp_cmd;

endpackage
`default_nettype wire

>>> sv/sspq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Request register, sorted slot array with parallel compare, and result register.
// ----------------------------------------------------------------------------
module sspq_dp
    import sspq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic                     i_command,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic [PRIO_IN_W-1:0]     i_priority_req,
    output logic signed [DATA_W-1:0]      o_front_value,
    output logic                          o_was_empty,
    output logic                          o_dropped_full,
    output logic [OCC_W-1:0]              o_occupancy
);

    logic              r_cmd;
    logic [DATA_W-1:0] r_value;
    logic [PRIO_W-1:0] r_prio;

    logic [DATA_W-1:0] r_slot_data [CAPACITY];
    logic [PRIO_W-1:0] r_slot_prio [CAPACITY];
    logic [DATA_W-1:0] n_slot_data [CAPACITY];
    logic [PRIO_W-1:0] n_slot_prio [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] n_front;
    logic              r_empty;
    logic              r_full;

    logic [CAPACITY-1:0] stay;
    logic                is_full;
    logic                is_empty;
    logic                do_insert;
    logic                do_remove;

    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign do_insert = (r_cmd == CMD_INSERT) && !is_full;
    assign do_remove = (r_cmd == CMD_REMOVE) && !is_empty;

    // A slot keeps its entry on insert when it is occupied and its priority is
    // not below the new one; the sorted order makes these bits a prefix.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            stay[i] = (CNT_W'(i) < r_count) && (r_slot_prio[i] >= r_prio);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_slot_data[i] = r_slot_data[i];
            n_slot_prio[i] = r_slot_prio[i];
        end
        n_count = r_count;
        n_front = '0;
        if (do_insert) begin
            if (!stay[0]) begin
                n_slot_data[0] = r_value;
                n_slot_prio[0] = r_prio;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!stay[i]) begin
                    if (stay[i-1]) begin
                        n_slot_data[i] = r_value;
                        n_slot_prio[i] = r_prio;
                    end else begin
                        n_slot_data[i] = r_slot_data[i-1];
                        n_slot_prio[i] = r_slot_prio[i-1];
                    end
                end
            end
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_front = r_slot_data[0];
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_slot_data[i] = r_slot_data[i+1];
                n_slot_prio[i] = r_slot_prio[i+1];
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_value <= i_entry_value;
            r_prio  <= i_priority_req[PRIO_W-1:0];
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_slot_data[i] <= n_slot_data[i];
                r_slot_prio[i] <= n_slot_prio[i];
            end
            r_front <= n_front;
            r_empty <= (r_cmd == CMD_REMOVE) && is_empty;
            r_full  <= (r_cmd == CMD_INSERT) && is_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    assign o_front_value  = r_front;
    assign o_was_empty    = r_empty;
    assign o_dropped_full = r_full;
    assign o_occupancy    = OCC_W'(r_count);

endmodule
`default_nettype wire

>>> sv/sspq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences capture and execution of each request and owns the result valid.
// ----------------------------------------------------------------------------
module sspq_ctrl
    import sspq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic capture;
    logic execute;

    assign capture = i_in_valid && (r_state == S_IDLE);
    // The result register may only be reloaded once the previous result is gone.
    assign execute = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (execute) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.execute = execute;

endmodule
`default_nettype wire

>>> sv/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Bounded queue kept sorted by priority; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Each request is first captured; then all slots compare their priority
// against the new one in parallel and shift by at most one place, loading
// the result register. A new request is accepted only once the previous one
// has updated the slots; an untaken result holds the next request in its
// update cycle. An insert into a full queue and a remove from an empty one
// leave the contents untouched and raise their flags.
module stable_sorted_priority_queue
    import sspq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_command,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic [PRIO_IN_W-1:0]     i_priority_req,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [DATA_W-1:0]      o_front_value,
    output logic                          o_was_empty,
    output logic                          o_dropped_full,
    output logic [OCC_W-1:0]              o_occupancy
);

    t_dp_cmd dp_cmd;

    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    sspq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_command),
        .i_entry_value  (i_entry_value),
        .i_priority_req (i_priority_req),
        .o_front_value  (o_front_value),
        .o_was_empty    (o_was_empty),
        .o_dropped_full (o_dropped_full),
        .o_occupancy    (o_occupancy)
    );

endmodule
`default_nettype wire
